// ----- design/trm_pkg.sv -----
// shared types and constants for the register machine step block
package trm_pkg;

    localparam int WordWidth  = 32;
    localparam int PcWidth    = 16;
    localparam int DataDepth  = 512;
    localparam int CallDepth  = 32;
    localparam int DataAw     = $clog2(DataDepth);
    localparam int CallAw     = $clog2(CallDepth);

    localparam logic [4:0] FN_MOV = 5'd0;
    localparam logic [4:0] FN_ADD = 5'd1;
    localparam logic [4:0] FN_SUB = 5'd2;
    localparam logic [4:0] FN_MUL = 5'd3;
    localparam logic [4:0] FN_DIV = 5'd4;
    localparam logic [4:0] FN_MOD = 5'd5;
    localparam logic [4:0] FN_JMP = 5'd6;
    localparam logic [4:0] FN_JMZ = 5'd7;
    localparam logic [4:0] FN_JNZ = 5'd8;
    localparam logic [4:0] FN_JSR = 5'd9;
    localparam logic [4:0] FN_RTS = 5'd10;
    localparam logic [4:0] FN_EXT = 5'd11;
    localparam logic [4:0] FN_PSH = 5'd12;
    localparam logic [4:0] FN_POP = 5'd13;
    localparam logic [4:0] FN_PUT = 5'd14;
    localparam logic [4:0] FN_GET = 5'd15;
    localparam logic [4:0] FN_OUT = 5'd16;
    localparam logic [4:0] FN_SRT = 5'd17;

    localparam logic [1:0] SK_NUM    = 2'd0;
    localparam logic [1:0] SK_REG    = 2'd1;
    localparam logic [1:0] SK_STR    = 2'd2;

    localparam logic [1:0] OK_NONE   = 2'd0;
    localparam logic [1:0] OK_NUMBER = 2'd1;
    localparam logic [1:0] OK_STRING = 2'd2;
    localparam logic [1:0] OK_EXIT   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd1;
    localparam logic [2:0] ST_STACK_OVF = 3'd2;
    localparam logic [2:0] ST_STACK_UNF = 3'd3;
    localparam logic [2:0] ST_CALL_OVF  = 3'd4;
    localparam logic [2:0] ST_CALL_UNF  = 3'd5;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd6;

    typedef struct packed {
        logic [4:0]           func;
        logic [PcWidth-1:0]   pc;
        logic [1:0]           dest_reg;
        logic [1:0]           src_kind;
        logic [1:0]           src_reg;
        logic signed [31:0]   imm;
        logic [PcWidth-1:0]   target_pos;
        logic                 addr_is_reg;
        logic [1:0]           addr_reg;
        logic [15:0]          addr_imm;
    } trm_in_t;

    typedef struct packed {
        logic [PcWidth-1:0]   next_pc;
        logic [1:0]           out_kind;
        logic signed [31:0]   out_value;
        logic [2:0]           status;
        logic                 zflag_now;
        logic                 finished;
    } trm_out_t;

endpackage

// ----- design/trm_ram.sv -----
// generic single-port ram with registered read
module trm_ram #(
    parameter int Width = 32,
    parameter int Depth = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/toy_register_machine_step.sv -----
// toy register machine: executes one decoded instruction per input word
// channels: s_ input word (s_valid/s_ready), m_ result word (m_valid/m_ready),
// cfg_we/cfg_wdata writes program_length; write only while idle (not enforced).
// every input word gives exactly one result word.
// most instructions step through accept, memory read and finish; mul adds
// a product write-back step, and div and mod by a nonzero value iterate in
// the shared restoring divider, which retires one quotient bit per cycle.
// mul uses one 32x32 multiplier with a registered product.
// the block handles one word at a time; s_ready is low while busy and
// while the result word waits in the output register; the next word can be
// accepted the cycle after the result is taken.
// after reset a clearing pass writes zero to all 512 data store entries,
// one per cycle, during which s_ready stays low.
// when the receiver stalls, the result holds in the output register.
// after ext, or when next_pc reaches program_length, every further
// instruction only reports finished until reset.
module toy_register_machine_step
    import trm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  trm_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output trm_out_t    m_data
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MULW, S_DIV, S_DONE
    } state_t;

    state_t state_reg;
    logic [15:0]          plen_reg;
    logic [WordWidth-1:0] regs_reg [4];
    logic                 zf_reg;
    logic [DataAw:0]      dtop_reg;
    logic [CallAw:0]      rtop_reg;
    logic                 halted_reg;
    trm_in_t              in_reg;
    trm_out_t             out_reg;
    logic [DataAw-1:0]    clr_reg;
    logic [5:0]           cnt_reg;
    logic [WordWidth-1:0] num_reg;
    logic [WordWidth-1:0] den_reg;
    logic [WordWidth-1:0] rem_reg;
    logic                 negq_reg;
    logic                 negr_reg;
    logic [WordWidth-1:0] prod_reg;

    // data store port
    logic                 d_we;
    logic [DataAw-1:0]    d_addr;
    logic [WordWidth-1:0] d_wdata;
    logic [WordWidth-1:0] d_rdata;
    // return store port
    logic                 r_we;
    logic [CallAw-1:0]    r_addr;
    logic [PcWidth-1:0]   r_rdata;

    trm_ram #(.Width(WordWidth), .Depth(DataDepth)) u_data (
        .aclk(aclk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );
    trm_ram #(.Width(PcWidth), .Depth(CallDepth)) u_call (
        .aclk(aclk), .we(r_we), .addr(r_addr), .wdata(in_reg.pc + 1'b1),
        .rdata(r_rdata)
    );

    logic [WordWidth-1:0] srcv;
    logic [WordWidth-1:0] immw;
    logic [WordWidth-1:0] dst;
    logic [WordWidth-1:0] paddr;
    logic                 paddr_ok;
    logic                 gaddr_ok;
    logic [WordWidth:0]   trial;

    always_comb begin
        immw = WordWidth'(in_reg.imm);
        srcv = (in_reg.src_kind == SK_REG) ? regs_reg[in_reg.src_reg] : immw;
        dst  = regs_reg[in_reg.dest_reg];
        paddr = in_reg.addr_is_reg ? regs_reg[in_reg.addr_reg]
                                   : WordWidth'(in_reg.addr_imm);
        paddr_ok = paddr < WordWidth'(DataDepth);
        gaddr_ok = in_reg.addr_imm < 16'(DataDepth);
        trial = {rem_reg, num_reg[WordWidth-1]} - {1'b0, den_reg};
    end

    // memory addressing: reads issued in S_READ, writes in S_EXEC (clearing writes in S_CLEAR)
    always_comb begin
        d_we    = 1'b0;
        d_addr  = clr_reg;
        d_wdata = '0;
        r_we    = 1'b0;
        r_addr  = rtop_reg[CallAw-1:0] - 1'b1;
        if (state_reg == S_CLEAR) begin
            d_we = 1'b1;
        end else if (in_reg.func == FN_POP) begin
            d_addr = dtop_reg[DataAw-1:0] - 1'b1;
        end else if (in_reg.func == FN_GET) begin
            d_addr = in_reg.addr_imm[DataAw-1:0];
        end else if (in_reg.func == FN_PSH) begin
            d_addr  = dtop_reg[DataAw-1:0];
            d_wdata = srcv;
            d_we    = (state_reg == S_EXEC) && !halted_reg
                      && dtop_reg < (DataAw+1)'(DataDepth);
        end else if (in_reg.func == FN_PUT) begin
            d_addr  = paddr[DataAw-1:0];
            d_wdata = srcv;
            d_we    = (state_reg == S_EXEC) && !halted_reg && paddr_ok;
        end
        if (in_reg.func == FN_JSR) begin
            r_addr = rtop_reg[CallAw-1:0];
            r_we   = (state_reg == S_EXEC) && !halted_reg
                     && rtop_reg < (CallAw+1)'(CallDepth);
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_DONE);
    assign m_data  = out_reg;

    // finishes an instruction: applies the halt rule to the result
    function automatic trm_out_t finish(input trm_out_t o, input logic [15:0] plen);
        trm_out_t r;
        r = o;
        if (r.next_pc >= plen) r.finished = 1'b1;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        trm_out_t o;
        logic [WordWidth-1:0] qv;
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            plen_reg   <= '0;
            zf_reg     <= 1'b0;
            dtop_reg   <= '0;
            rtop_reg   <= '0;
            halted_reg <= 1'b0;
            for (int i = 0; i < 4; i++) regs_reg[i] <= '0;
        end else begin
            if (cfg_we) plen_reg <= cfg_wdata;
            o = out_reg;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == DataAw'(DataDepth - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    o.next_pc       = in_reg.pc + 1'b1;
                    o.out_kind      = OK_NONE;
                    o.out_value     = '0;
                    o.status        = ST_OK;
                    o.zflag_now     = zf_reg;
                    o.finished      = 1'b0;
                    state_reg <= S_DONE;
                    if (halted_reg) begin
                        o.next_pc  = in_reg.pc;
                        o.finished = 1'b1;
                    end else begin
                        case (in_reg.func) inside
                            FN_MOV: begin
                                regs_reg[in_reg.dest_reg] <= srcv;
                                o.next_pc = in_reg.pc + 2'd3;
                            end
                            FN_ADD, FN_SUB: begin
                                qv = (in_reg.func == FN_ADD) ? dst + srcv : dst - srcv;
                                regs_reg[in_reg.dest_reg] <= qv;
                                zf_reg <= (qv == '0);
                                o.zflag_now = (qv == '0);
                                o.next_pc = in_reg.pc + 2'd3;
                            end
                            FN_MUL: begin
                                prod_reg  <= WordWidth'(dst * srcv);
                                o.next_pc = in_reg.pc + 2'd3;
                                state_reg <= S_MULW;
                            end
                            FN_DIV, FN_MOD: begin
                                o.next_pc = in_reg.pc + 2'd3;
                                if (srcv == '0) begin
                                    o.status = ST_DIV_ZERO;
                                end else begin
                                    num_reg  <= dst[WordWidth-1] ? -dst : dst;
                                    den_reg  <= srcv[WordWidth-1] ? -srcv : srcv;
                                    rem_reg  <= '0;
                                    cnt_reg  <= '0;
                                    negq_reg <= dst[WordWidth-1] ^ srcv[WordWidth-1];
                                    negr_reg <= dst[WordWidth-1];
                                    state_reg <= S_DIV;
                                end
                            end
                            FN_JMP: o.next_pc = in_reg.target_pos;
                            FN_JMZ: o.next_pc = zf_reg ? in_reg.target_pos
                                                       : in_reg.pc + 2'd2;
                            FN_JNZ: o.next_pc = zf_reg ? in_reg.pc + 2'd2
                                                       : in_reg.target_pos;
                            FN_JSR: begin
                                if (rtop_reg >= (CallAw+1)'(CallDepth)) begin
                                    o.status  = ST_CALL_OVF;
                                    o.next_pc = in_reg.pc + 2'd2;
                                end else begin
                                    rtop_reg  <= rtop_reg + 1'b1;
                                    o.next_pc = in_reg.target_pos + 1'b1;
                                end
                            end
                            FN_RTS: begin
                                if (rtop_reg == '0) begin
                                    o.status = ST_CALL_UNF;
                                end else begin
                                    rtop_reg  <= rtop_reg - 1'b1;
                                    o.next_pc = r_rdata + 1'b1;
                                end
                            end
                            FN_EXT: begin
                                o.out_kind  = OK_EXIT;
                                o.out_value = (in_reg.src_kind == SK_NUM) ? in_reg.imm
                                                                          : 32'sd1;
                                o.next_pc   = in_reg.pc;
                                o.finished  = 1'b1;
                            end
                            FN_PSH: begin
                                o.next_pc = in_reg.pc + 2'd2;
                                if (dtop_reg >= (DataAw+1)'(DataDepth))
                                    o.status = ST_STACK_OVF;
                                else
                                    dtop_reg <= dtop_reg + 1'b1;
                            end
                            FN_POP: begin
                                o.next_pc = in_reg.pc + 2'd2;
                                if (dtop_reg == '0) begin
                                    o.status = ST_STACK_UNF;
                                end else begin
                                    dtop_reg <= dtop_reg - 1'b1;
                                    regs_reg[in_reg.dest_reg] <= d_rdata;
                                end
                            end
                            FN_PUT: begin
                                o.next_pc = in_reg.pc + 2'd3;
                                if (!paddr_ok) o.status = ST_BAD_ADDR;
                            end
                            FN_GET: begin
                                o.next_pc = in_reg.pc + 2'd3;
                                if (!gaddr_ok) o.status = ST_BAD_ADDR;
                                else regs_reg[in_reg.dest_reg] <= d_rdata;
                            end
                            FN_OUT: begin
                                o.next_pc = in_reg.pc + 2'd2;
                                if (in_reg.src_kind inside {SK_NUM, SK_REG}) begin
                                    o.out_kind  = OK_NUMBER;
                                    o.out_value = srcv;
                                end else if (in_reg.src_kind == SK_STR) begin
                                    o.out_kind  = OK_STRING;
                                    o.out_value = in_reg.imm;
                                end else begin
                                    o.next_pc = in_reg.pc + 1'b1;
                                end
                            end
                            FN_SRT: o.next_pc = in_reg.target_pos + 1'b1;
                            default: ;
                        endcase
                        o = finish(o, plen_reg);
                        if (o.finished) halted_reg <= 1'b1;
                    end
                end
                S_MULW: begin
                    regs_reg[in_reg.dest_reg] <= prod_reg;
                    zf_reg <= (prod_reg == '0);
                    o.zflag_now = (prod_reg == '0);
                    state_reg <= S_DONE;
                end
                S_DIV: begin
                    // one quotient bit per cycle, quotient shifts into num_reg
                    if (cnt_reg == 6'(WordWidth)) begin
                        if (in_reg.func == FN_DIV)
                            qv = negq_reg ? -num_reg : num_reg;
                        else
                            qv = negr_reg ? -rem_reg : rem_reg;
                        regs_reg[in_reg.dest_reg] <= qv;
                        zf_reg <= (qv == '0);
                        o.zflag_now = (qv == '0);
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (!trial[WordWidth]) begin
                            rem_reg <= trial[WordWidth-1:0];
                            num_reg <= {num_reg[WordWidth-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[WordWidth-2:0], num_reg[WordWidth-1]};
                            num_reg <= {num_reg[WordWidth-2:0], 1'b0};
                        end
                    end
                end
                S_DONE: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            out_reg <= o;
        end
    end
endmodule
